// ----- hw/rtl/hdlcf_pkg.sv -----
// Shared types, command codes and constants for the HDLC bit-stuffing framer.
`default_nettype none

package hdlcf_pkg;

    // Command codes carried in the cmd field of an input beat.
    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_FLAG = 2'd1;
    localparam logic [1:0] CMD_FCS  = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    // Line and CRC constants.
    localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [7:0]  ONES_RUN_MASK = 8'h7C;

    // Number of result bytes one command can produce at most.
    localparam int unsigned BUF_DEPTH = 3;
    localparam int unsigned BUF_IDX_W = 2;

    // Bits left to send in one command (up to 16 for the FCS).
    localparam int unsigned LEFT_W = 5;

    // Input beat.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Start request from the sequencer to the bit engine.
    typedef struct packed {
        logic       go;
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } eng_start_t;

    // Completed line byte from the bit engine.
    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } byte_evt_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hdlcf_bit_engine.sv -----
// Bit-serial engine: one line bit per cycle, CRC update, zero stuffing, byte packing.
`default_nettype none

module hdlcf_bit_engine (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire hdlcf_pkg::eng_start_t start_i,
    output logic                       busy_o,
    output logic                       done_o,
    output hdlcf_pkg::byte_evt_t       byte_o
);

    logic [15:0]                   crc_reg, crc_next;
    logic [7:0]                    hist_reg, hist_next;
    logic [2:0]                    cnt_reg, cnt_next;
    logic [15:0]                   sh_reg, sh_next;
    logic [hdlcf_pkg::LEFT_W-1:0]  left_reg, left_next;
    logic                          stuff_pend_reg, stuff_pend_next;
    logic                          stuff_en_reg, stuff_en_next;
    logic                          crc_upd_reg, crc_upd_next;
    logic                          busy_reg, busy_next;

    logic       line_bit;
    logic [7:0] hist_full;
    logic [7:0] hist_shifted;
    logic       fb;
    logic       step_done;

    // One step: push the current line bit, advance CRC and stuffing check.
    always_comb begin
        crc_next        = crc_reg;
        hist_next       = hist_reg;
        cnt_next        = cnt_reg;
        sh_next         = sh_reg;
        left_next       = left_reg;
        stuff_pend_next = stuff_pend_reg;
        stuff_en_next   = stuff_en_reg;
        crc_upd_next    = crc_upd_reg;
        busy_next       = busy_reg;
        step_done       = 1'b0;

        line_bit     = stuff_pend_reg ? 1'b0 : sh_reg[0];
        hist_full    = {line_bit, hist_reg[6:0]};
        hist_shifted = {1'b0, hist_full[7:1]};
        fb           = crc_reg[0] ^ sh_reg[0];

        if (busy_reg) begin
            hist_next = hist_shifted;
            cnt_next  = cnt_reg + 3'd1;
            if (stuff_pend_reg) begin
                stuff_pend_next = 1'b0;
                step_done       = (left_reg == '0);
            end else begin
                sh_next   = {1'b0, sh_reg[15:1]};
                left_next = left_reg - {{(hdlcf_pkg::LEFT_W-1){1'b0}}, 1'b1};
                if (crc_upd_reg) begin
                    crc_next = {1'b0, crc_reg[15:1]} ^
                               (fb ? hdlcf_pkg::CRC_POLY_REFL : 16'h0000);
                end
                stuff_pend_next = stuff_en_reg &&
                    ((hist_shifted & hdlcf_pkg::ONES_RUN_MASK) == hdlcf_pkg::ONES_RUN_MASK);
                step_done = (left_reg == {{(hdlcf_pkg::LEFT_W-1){1'b0}}, 1'b1}) &&
                            !stuff_pend_next;
            end
            if (step_done) begin
                busy_next = 1'b0;
            end
        end else if (start_i.go) begin
            // Load the bits of the new command.
            busy_next       = 1'b1;
            stuff_pend_next = 1'b0;
            unique case (start_i.cmd)
                hdlcf_pkg::CMD_DATA: begin
                    sh_next       = {8'h00, start_i.data_byte};
                    left_next     = hdlcf_pkg::LEFT_W'(8);
                    stuff_en_next = 1'b1;
                    crc_upd_next  = 1'b1;
                end
                hdlcf_pkg::CMD_FLAG: begin
                    sh_next       = {8'h00, hdlcf_pkg::FLAG_BYTE};
                    left_next     = hdlcf_pkg::LEFT_W'(8);
                    stuff_en_next = 1'b0;
                    crc_upd_next  = 1'b0;
                    crc_next      = hdlcf_pkg::CRC_INIT;
                end
                hdlcf_pkg::CMD_FCS: begin
                    sh_next       = ~crc_reg;
                    left_next     = hdlcf_pkg::LEFT_W'(16);
                    stuff_en_next = 1'b1;
                    crc_upd_next  = 1'b0;
                    crc_next      = hdlcf_pkg::CRC_INIT;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= hdlcf_pkg::CRC_INIT;
            hist_reg       <= 8'h00;
            cnt_reg        <= 3'd0;
            busy_reg       <= 1'b0;
            stuff_pend_reg <= 1'b0;
        end else begin
            crc_reg        <= crc_next;
            hist_reg       <= hist_next;
            cnt_reg        <= cnt_next;
            busy_reg       <= busy_next;
            stuff_pend_reg <= stuff_pend_next;
        end
    end

    // Per-command working registers.
    always_ff @(posedge aclk) begin
        sh_reg       <= sh_next;
        left_reg     <= left_next;
        stuff_en_reg <= stuff_en_next;
        crc_upd_reg  <= crc_upd_next;
    end

    // A byte completes when the eighth bit lands in the history register.
    assign byte_o.valid = busy_reg && (cnt_next == 3'd0);
    assign byte_o.value = hist_full;
    assign busy_o       = busy_reg;
    assign done_o       = busy_reg && step_done;

endmodule

`default_nettype wire

// ----- hw/rtl/hdlcf_out_buf.sv -----
// Result buffer: gathers the bytes of one command and drains them through an output register.
`default_nettype none

module hdlcf_out_buf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hdlcf_pkg::byte_evt_t byte_i,
    input  wire logic                 drain_i,
    output logic                      drained_o,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output hdlcf_pkg::out_item_t      m_item
);

    logic [7:0]                       buf_mem [hdlcf_pkg::BUF_DEPTH];
    logic [hdlcf_pkg::BUF_IDX_W-1:0]  wr_reg, wr_next;
    logic [hdlcf_pkg::BUF_IDX_W-1:0]  rd_reg, rd_next;
    logic                             m_valid_reg, m_valid_next;
    hdlcf_pkg::out_item_t             m_item_reg;
    logic                             load;
    logic                             empty;

    assign empty     = (rd_reg == wr_reg);
    assign load      = drain_i && !empty && (!m_valid_reg || m_ready);
    assign drained_o = drain_i && empty;

    // Pointer and output valid control.
    always_comb begin
        wr_next      = wr_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (byte_i.valid) begin
            wr_next = wr_reg + {{(hdlcf_pkg::BUF_IDX_W-1){1'b0}}, 1'b1};
        end
        if (load) begin
            m_valid_next = 1'b1;
            rd_next      = rd_reg + {{(hdlcf_pkg::BUF_IDX_W-1){1'b0}}, 1'b1};
        end
        if (drained_o) begin
            wr_next = '0;
            rd_next = '0;
        end
    end

    // Byte store.
    always_ff @(posedge aclk) begin
        if (byte_i.valid) begin
            buf_mem[wr_reg] <= byte_i.value;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg      <= '0;
            rd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register: takes the oldest gathered byte when the result side allows.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg.out_byte    <= buf_mem[rd_reg];
            m_item_reg.last_of_run <=
                (rd_reg + {{(hdlcf_pkg::BUF_IDX_W-1){1'b0}}, 1'b1}) == wr_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/hdlc_framer_bit_stuffer_unit.sv -----
// Top level of the HDLC framer: command sequencer, bit engine and result buffer.
`default_nettype none

// HDLC framer with zero-bit stuffing and CRC-16-CCITT FCS. Each input beat is
// a command: send a data byte (CRC updated, stuffed), send a 0x7E flag
// (unstuffed, CRC restarted) or end the frame (complemented FCS sent low byte
// first, stuffed, CRC restarted). Line bits are packed LSB first into output
// bytes that carry over between commands; last_of_run marks the final byte a
// command produced, and a command that completes no byte produces no beat.
// Command code 3 is accepted and ignored. The bit engine sends one line bit
// per clock, stuffed zeros included; a command is accepted, its bits are sent
// by the engine, and then the bytes it produced are drained through the output
// register, one per clock when the result side is ready. s_ready is low from
// the acceptance of a data, flag or FCS command until the block has returned to
// idle after the last result byte has moved into the output register.
module hdlc_framer_bit_stuffer_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire hdlcf_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output hdlcf_pkg::out_item_t      m_item
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]            state_reg, state_next;
    hdlcf_pkg::eng_start_t eng_start;
    hdlcf_pkg::byte_evt_t  byte_evt;
    logic                  eng_busy;
    logic                  eng_done;
    logic                  drained;
    logic                  accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign eng_start.go        = accept && (s_item.cmd != hdlcf_pkg::CMD_RSVD);
    assign eng_start.cmd       = s_item.cmd;
    assign eng_start.data_byte = s_item.data_byte;

    // Sequencer: accept, run the bit engine, then drain the gathered bytes.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (eng_start.go) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (eng_done || !eng_busy) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    hdlcf_bit_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (eng_start),
        .busy_o  (eng_busy),
        .done_o  (eng_done),
        .byte_o  (byte_evt)
    );

    hdlcf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_i    (byte_evt),
        .drain_i   (state_reg == ST_DRAIN),
        .drained_o (drained),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/hdlcf_checker.sv -----
// Port-level checker for the HDLC framer, bound to the top level.
`default_nettype none

module hdlcf_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire hdlcf_pkg::in_item_t s_item,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire hdlcf_pkg::out_item_t m_item
);

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result beat changed while stalled");

    // A real command makes the block busy on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.cmd != hdlcf_pkg::CMD_RSVD)) |=> !s_ready)
        else $error("block stayed ready after a command");

    // The unused command code does not stall the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.cmd == hdlcf_pkg::CMD_RSVD)) |=> s_ready)
        else $error("unused command stalled the input");

    // A byte that is not the last of its command is shown only while busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.last_of_run) |-> !s_ready)
        else $error("non-final byte shown while ready for input");

endmodule

bind hdlc_framer_bit_stuffer_unit hdlcf_checker u_hdlcf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
